### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the RTP sequence validator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/rsv_pkg.sv
// ----------------------------------------------------------------------------
// rsv_pkg
// Types and constants of the RTP sequence validator.
// ----------------------------------------------------------------------------
package rsv_pkg;

  localparam int PT_W   = 7;
  localparam int SEQ_W  = 16;
  localparam int SSRC_W = 32;
  localparam int GAP_W  = 15;
  localparam int PROB_W = 4;
  localparam int STAT_W = 3;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 15;

  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_PT    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DROPOUT_LIMIT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MISORDER_LIMIT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PROBATION_LEN  = 3'd3;

  localparam logic [PT_W-1:0]   RESET_EXPECTED_PT    = 7'd0;
  localparam logic [GAP_W-1:0]  RESET_DROPOUT_LIMIT  = 15'd3000;
  localparam logic [GAP_W-1:0]  RESET_MISORDER_LIMIT = 15'd100;
  localparam logic [PROB_W-1:0] RESET_PROBATION_LEN  = 4'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_PROBATION = 3'd1;
  localparam logic [STAT_W-1:0] ST_RESTART   = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADSEQ    = 3'd3;
  localparam logic [STAT_W-1:0] ST_BADPT     = 3'd4;

  // Sequence span and the "matches nothing" bad sequence mark.
  localparam logic [SEQ_W:0] SEQ_SPAN = 17'h10000;
  localparam logic [SEQ_W:0] BAD_NONE = 17'h10001;

  typedef struct packed {
    logic [PT_W-1:0]   payload_type;
    logic [SEQ_W-1:0]  seq_number;
    logic [SSRC_W-1:0] source_id;
  } rsv_hdr_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [31:0]       extended_seq;
    logic [31:0]       packets_counted;
    logic [SSRC_W-1:0] peer_id;
  } rsv_res_t;

endpackage

### design/rtp_sequence_validator.sv
// ----------------------------------------------------------------------------
// rtp_sequence_validator
// RFC 3550 style sequence validation of received RTP headers: peer latch,
// payload type check, probation, dropout and misorder tracking.
// ----------------------------------------------------------------------------
//   channel  direction  handshake            payload
//   hdr      in         hdr_valid/hdr_stall  rsv_hdr_t (pt, seq, ssrc)
//   res      out        res_valid/res_stall  rsv_res_t (status, ext seq, count, peer)
//   cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One header per cycle unless stalled; a result passes the input register,
// then the output register. The tracker state updates in the single evaluation
// stage after the input register. A two-entry output register absorbs result
// stalls; the input stalls only when both entries and the input register are
// full. Reset restores the register defaults and clears all tracking state.
// ----------------------------------------------------------------------------
module rtp_sequence_validator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               hdr_valid,
  output logic                               hdr_stall,
  input  rsv_pkg::rsv_hdr_t                  hdr,
  output logic                               res_valid,
  input  logic                               res_stall,
  output rsv_pkg::rsv_res_t                  res,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rsv_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rsv_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rsv_pkg::*;

  logic [PT_W-1:0]   expected_pt;
  logic [GAP_W-1:0]  dropout_limit;
  logic [GAP_W-1:0]  misorder_limit;
  logic [PROB_W-1:0] probation_len;

  logic [SSRC_W-1:0] peer_source;
  logic [31:0]       received_count;
  logic [SEQ_W-1:0]  highest_sequence;
  logic [SEQ_W:0]    bad_sequence;
  logic [SEQ_W-1:0]  wrap_count;
  logic [PROB_W-1:0] probation_left;

  logic [SSRC_W-1:0] peer_source_next;
  logic [31:0]       received_count_next;
  logic [SEQ_W-1:0]  highest_sequence_next;
  logic [SEQ_W:0]    bad_sequence_next;
  logic [SEQ_W-1:0]  wrap_count_next;
  logic [PROB_W-1:0] probation_left_next;
  logic [STAT_W-1:0] status_next;

  logic              s1_valid;
  rsv_hdr_t          s1;
  logic              skid_valid;
  rsv_res_t          skid;
  logic              advance;
  logic              push;
  logic              pop;
  rsv_res_t          result;

  logic [SEQ_W-1:0]  seq;
  logic [SEQ_W-1:0]  gap;
  logic [SEQ_W-1:0]  hi_w;
  logic [PROB_W-1:0] prob_w;
  logic [SEQ_W:0]    bad_w;
  logic [SEQ_W-1:0]  wrap_w;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_pt    <= RESET_EXPECTED_PT;
      dropout_limit  <= RESET_DROPOUT_LIMIT;
      misorder_limit <= RESET_MISORDER_LIMIT;
      probation_len  <= RESET_PROBATION_LEN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EXPECTED_PT:    expected_pt    <= cfg_data[PT_W-1:0];
        REG_DROPOUT_LIMIT:  dropout_limit  <= cfg_data[GAP_W-1:0];
        REG_MISORDER_LIMIT: misorder_limit <= cfg_data[GAP_W-1:0];
        REG_PROBATION_LEN:  probation_len  <= cfg_data[PROB_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register; advance while the output side has a free entry.
  assign advance   = !skid_valid;
  assign hdr_stall = s1_valid && !advance;
  assign push      = s1_valid && advance;
  assign pop       = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!hdr_stall) begin
      s1_valid <= hdr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_valid && !hdr_stall) begin
      s1 <= hdr;
    end
  end

  always_comb begin
    seq                   = s1.seq_number;
    peer_source_next      = (peer_source == '0) ? s1.source_id : peer_source;
    received_count_next   = received_count;
    highest_sequence_next = highest_sequence;
    bad_sequence_next     = bad_sequence;
    wrap_count_next       = wrap_count;
    probation_left_next   = probation_left;
    status_next           = ST_OK;
    hi_w                  = highest_sequence;
    prob_w                = probation_left;
    bad_w                 = bad_sequence;
    wrap_w                = wrap_count;
    gap                   = '0;

    if (s1.payload_type != expected_pt) begin
      status_next = ST_BADPT;
    end else begin
      if (received_count == '0) begin
        hi_w   = seq - 16'd1;
        bad_w  = BAD_NONE;
        wrap_w = '0;
        prob_w = probation_len;
      end
      gap = seq - hi_w;

      if (prob_w != '0) begin
        if ({1'b0, seq} == {1'b0, hi_w} + 17'd1) begin
          prob_w = prob_w - 4'd1;
          status_next = (prob_w == '0) ? ST_RESTART : ST_PROBATION;
        end else begin
          prob_w = probation_len - 4'd1;
          status_next = ST_PROBATION;
        end
        hi_w = seq;
      end else if ({1'b0, gap} < {2'b0, dropout_limit}) begin
        if (seq < hi_w) begin
          wrap_w = wrap_w + 16'd1;
        end
        hi_w = seq;
        status_next = ST_OK;
      end else if ({1'b0, gap} <= SEQ_SPAN - {2'b0, misorder_limit}) begin
        if ({1'b0, seq} == bad_w) begin
          status_next = ST_RESTART;
        end else begin
          bad_w = {1'b0, seq + 16'd1};
          status_next = ST_BADSEQ;
        end
      end else begin
        status_next = ST_OK;
      end

      if (status_next == ST_RESTART) begin
        hi_w   = seq;
        bad_w  = BAD_NONE;
        wrap_w = '0;
      end
      if (status_next != ST_BADSEQ) begin
        received_count_next = received_count + 32'd1;
      end
      highest_sequence_next = hi_w;
      bad_sequence_next     = bad_w;
      wrap_count_next       = wrap_w;
      probation_left_next   = prob_w;
    end

    result.status          = status_next;
    result.extended_seq    = {wrap_count_next, highest_sequence_next};
    result.packets_counted = received_count_next;
    result.peer_id         = peer_source_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peer_source      <= '0;
      received_count   <= '0;
      highest_sequence <= '0;
      bad_sequence     <= '0;
      wrap_count       <= '0;
      probation_left   <= '0;
    end else if (push) begin
      peer_source      <= peer_source_next;
      received_count   <= received_count_next;
      highest_sequence <= highest_sequence_next;
      bad_sequence     <= bad_sequence_next;
      wrap_count       <= wrap_count_next;
      probation_left   <= probation_left_next;
    end
  end

  // Two-entry output register: res is the head, skid holds the second.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (pop) begin
          res_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (res_valid) begin
        if (pop) begin
          res_valid <= push;
        end else if (push) begin
          skid_valid <= 1'b1;
        end
      end else begin
        res_valid <= push;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        res <= skid;
      end
    end else if (push && (pop || !res_valid)) begin
      res <= result;
    end else if (push) begin
      skid <= result;
    end
  end

  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_skid_behind_head, skid_valid |-> res_valid, "skid entry without head entry")
  `ASSERT_CLK(a_stall_only_full, hdr_stall |-> (s1_valid && skid_valid),
              "input stalled with free entry")
  `ASSERT_CLK(a_peer_sticky, (peer_source != '0) |=> (peer_source == $past(peer_source)),
              "peer changed after latch")
  `ASSERT_CLK(a_badpt_no_count,
              (push && status_next == ST_BADPT) |=> (received_count == $past(received_count)),
              "bad payload type changed count")

endmodule

### dv/tb_rtp_sequence_validator.sv
// ----------------------------------------------------------------------------
// tb_rtp_sequence_validator
// Self-checking testbench of the RTP sequence validator. A directed run walks
// the peer latch, payload type rejection, probation (including the 65535
// no-match and the wrapped probation reload), dropout and misorder windows,
// jump resync and the sequence wrap. Five register settings, the extremes
// among them, then carry random well-formed streams mixed with noise. The
// sender works in bursts, the receiver stalls on its own pattern and now and
// then holds off long enough to back up the block. Every result is checked
// field by field against an in-order prediction.
// ----------------------------------------------------------------------------
module tb_rtp_sequence_validator;
  timeunit 1ns;
  timeprecision 1ps;

  import rsv_pkg::*;

  class rtp_rx_scoreboard;
    logic [PT_W-1:0]   want_pt;
    logic [GAP_W-1:0]  dropout_limit;
    logic [GAP_W-1:0]  misorder_limit;
    logic [PROB_W-1:0] probation_len;

    logic [SSRC_W-1:0] peer;
    logic [31:0]       rx_count;
    logic [SEQ_W-1:0]  top_seq;
    logic [SEQ_W:0]    bad_mark;
    logic [15:0]       wraps;
    logic [PROB_W-1:0] probation;

    rsv_res_t pending_reports[$];
    int       errors;

    function new();
      want_pt        = RESET_EXPECTED_PT;
      dropout_limit  = RESET_DROPOUT_LIMIT;
      misorder_limit = RESET_MISORDER_LIMIT;
      probation_len  = RESET_PROBATION_LEN;
      peer     = '0;
      rx_count = '0;
      top_seq  = '0;
      bad_mark = '0;
      wraps    = '0;
      probation = '0;
      errors   = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_EXPECTED_PT:    want_pt = data[PT_W-1:0];
        REG_DROPOUT_LIMIT:  dropout_limit = data;
        REG_MISORDER_LIMIT: misorder_limit = data;
        REG_PROBATION_LEN:  probation_len = data[PROB_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [STAT_W-1:0] advance_tracker(logic [SEQ_W-1:0] seq);
      logic [SEQ_W-1:0] gap;
      gap = seq - top_seq;
      if (probation != 0) begin
        if ({1'b0, seq} == {1'b0, top_seq} + 17'd1) begin
          probation = probation - 4'd1;
          top_seq = seq;
          if (probation == 0) return ST_RESTART;
        end else begin
          probation = probation_len - 4'd1;
          top_seq = seq;
        end
        return ST_PROBATION;
      end
      if (gap < {1'b0, dropout_limit}) begin
        if (seq < top_seq) wraps = wraps + 16'd1;
        top_seq = seq;
      end else if ({1'b0, gap} <= SEQ_SPAN - {2'b00, misorder_limit}) begin
        if ({1'b0, seq} == bad_mark) return ST_RESTART;
        bad_mark = {1'b0, seq + 16'd1};
        return ST_BADSEQ;
      end
      return ST_OK;
    endfunction

    function void take_header(rsv_hdr_t h);
      rsv_res_t r;
      logic [STAT_W-1:0] st;
      if (peer == 0) peer = h.source_id;
      if (h.payload_type != want_pt) begin
        st = ST_BADPT;
      end else begin
        if (rx_count == 0) begin
          bad_mark  = BAD_NONE;
          wraps     = '0;
          top_seq   = h.seq_number - 16'd1;
          probation = probation_len;
        end
        st = advance_tracker(h.seq_number);
        if (st == ST_RESTART) begin
          top_seq  = h.seq_number;
          bad_mark = BAD_NONE;
          wraps    = '0;
          rx_count = rx_count + 32'd1;
        end else if (st == ST_OK || st == ST_PROBATION) begin
          rx_count = rx_count + 32'd1;
        end
      end
      r.status          = st;
      r.extended_seq    = {wraps, top_seq};
      r.packets_counted = rx_count;
      r.peer_id         = peer;
      pending_reports.push_back(r);
    endfunction

    function void check_status(rsv_res_t got);
      rsv_res_t want;
      if (pending_reports.size() == 0) begin
        $error("result with no request pending: status %0d ext %h", got.status,
               got.extended_seq);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.extended_seq !== want.extended_seq) begin
        $error("extended_seq: expected %h, actual %h", want.extended_seq, got.extended_seq);
        errors++;
      end
      if (got.packets_counted !== want.packets_counted) begin
        $error("packets_counted: expected %0d, actual %0d", want.packets_counted,
               got.packets_counted);
        errors++;
      end
      if (got.peer_id !== want.peer_id) begin
        $error("peer_id: expected %h, actual %h", want.peer_id, got.peer_id);
        errors++;
      end
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic hdr_valid = 1'b0;
  logic hdr_stall;
  rsv_hdr_t hdr = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  rsv_res_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  rtp_rx_scoreboard sb = new();
  int items_sent = 0;
  int burst_left = 1;
  int floods_req = 0;
  logic [SEQ_W-1:0] stream_seq = '0;

  rtp_sequence_validator dut (
    .clk       (clk),
    .rst       (rst),
    .hdr_valid (hdr_valid),
    .hdr_stall (hdr_stall),
    .hdr       (hdr),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_status(res);
  end

  function automatic rsv_hdr_t make_hdr(logic [PT_W-1:0] pt, logic [SEQ_W-1:0] seq,
                                        logic [SSRC_W-1:0] id);
    rsv_hdr_t h;
    h.payload_type = pt;
    h.seq_number   = seq;
    h.source_id    = id;
    return h;
  endfunction

  task automatic send_hdr(rsv_hdr_t h);
    int gap;
    hdr_valid <= 1'b1;
    hdr <= h;
    @(posedge clk);
    while (hdr_stall) @(posedge clk);
    sb.take_header(h);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        hdr_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(logic [PT_W-1:0] pt, logic [GAP_W-1:0] drop,
                           logic [GAP_W-1:0] mis, logic [PROB_W-1:0] minseq);
    write_reg(REG_EXPECTED_PT, {8'($urandom), pt});
    write_reg(REG_DROPOUT_LIMIT, drop);
    write_reg(REG_MISORDER_LIMIT, mis);
    write_reg(REG_PROBATION_LEN, {11'($urandom), minseq});
    write_reg(3'($urandom_range(4, 7)), 15'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // drop the request line and wait out every outstanding result
  task automatic settle();
    hdr_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_random_item();
    int pick;
    int span;
    int window;
    logic [SEQ_W-1:0] jump_seq;
    rsv_hdr_t h;
    pick = $urandom_range(0, 99);
    h = make_hdr(sb.want_pt, stream_seq, $urandom);
    if (pick < 55) begin
      stream_seq = stream_seq + 16'd1;
      h.seq_number = stream_seq;
    end else if (pick < 67) begin
      span = (sb.dropout_limit > 1) ? int'(sb.dropout_limit) - 1 : 1;
      stream_seq = stream_seq + 16'($urandom_range(1, span));
      h.seq_number = stream_seq;
    end else if (pick < 72) begin
      h.seq_number = stream_seq;
    end else if (pick < 78) begin
      h.seq_number = stream_seq - 16'($urandom_range(1, 200));
    end else if (pick < 88) begin
      window = 65536 - int'(sb.misorder_limit) - int'(sb.dropout_limit);
      if (window < 0) window = 0;
      jump_seq = stream_seq + 16'(int'(sb.dropout_limit) + $urandom_range(0, window));
      h.seq_number = jump_seq;
      send_hdr(h);
      h = make_hdr(sb.want_pt, jump_seq + 16'd1, $urandom);
      if ($urandom_range(0, 3) == 0) h.seq_number = 16'($urandom);
      else stream_seq = jump_seq + 16'd1;
    end else if (pick < 94) begin
      h.seq_number = 16'($urandom);
    end else begin
      h.payload_type = sb.want_pt ^ 7'($urandom_range(1, 127));
      h.seq_number = 16'($urandom);
    end
    send_hdr(h);
  endtask

  initial begin
    int mode;
    int len;
    int pct;
    int done_floods;
    done_floods = 0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (done_floods < floods_req) begin
        res_stall <= 1'b1;
        repeat (400) @(posedge clk);
        done_floods++;
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(1, 50);
        case (mode)
          0: pct = 0;
          1: pct = 25;
          2: pct = 50;
          default: pct = 85;
        endcase
        repeat (len) begin
          res_stall <= ($urandom_range(1, 100) <= pct);
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int goal;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_hdr(make_hdr(7'd1, 16'h1234, 32'h0000_0000));
    send_hdr(make_hdr(7'd1, 16'h0000, 32'hFFFF_FFFF));
    send_hdr(make_hdr(7'd0, 16'hFFFF, $urandom));
    send_hdr(make_hdr(7'd0, 16'h0000, $urandom));
    settle();
    configure(sb.want_pt, sb.dropout_limit, sb.misorder_limit, 4'd0);
    send_hdr(make_hdr(7'd0, 16'd9, $urandom));
    settle();
    configure(sb.want_pt, sb.dropout_limit, sb.misorder_limit, RESET_PROBATION_LEN);
    send_hdr(make_hdr(7'd0, 16'd20, $urandom));
    send_hdr(make_hdr(7'd0, 16'd21, $urandom));
    send_hdr(make_hdr(7'd0, 16'd22, $urandom));
    send_hdr(make_hdr(7'd0, 16'd22, $urandom));
    send_hdr(make_hdr(7'd0, 16'd21, $urandom));
    send_hdr(make_hdr(7'd0, 16'd3022, $urandom));
    send_hdr(make_hdr(7'd0, 16'd3023, $urandom));
    send_hdr(make_hdr(7'd0, 16'd6022, $urandom));
    send_hdr(make_hdr(7'd0, 16'd5922, $urandom));
    send_hdr(make_hdr(7'd0, 16'd5923, $urandom));
    send_hdr(make_hdr(7'd0, 16'd65530, $urandom));
    send_hdr(make_hdr(7'd0, 16'd65531, $urandom));
    send_hdr(make_hdr(7'd0, 16'd65535, $urandom));
    send_hdr(make_hdr(7'd0, 16'd2, $urandom));
    send_hdr(make_hdr(7'h7F, 16'hFFFF, 32'hFFFF_FFFF));
    stream_seq = 16'd2;

    for (int p = 0; p < 5; p++) begin
      settle();
      case (p)
        0: configure(RESET_EXPECTED_PT, RESET_DROPOUT_LIMIT, RESET_MISORDER_LIMIT,
                     RESET_PROBATION_LEN);
        1: configure(7'h7F, 15'h7FFF, 15'h7FFF, 4'hF);
        2: configure(7'h55, 15'd1, 15'd1, 4'd1);
        3: configure(7'h2A, 15'd0, 15'd0, 4'd0);
        default: configure(7'($urandom), 15'($urandom_range(1, 32767)),
                           15'($urandom_range(1, 32767)), 4'($urandom_range(1, 15)));
      endcase
      floods_req++;
      goal = items_sent + 250;
      while (items_sent < goal) send_random_item();
    end

    settle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/rsv_pkg.sv
design/rtp_sequence_validator.sv
dv/tb_rtp_sequence_validator.sv
